@@ sv/biquad_iir_fixed_point_top_macros.svh @@
// Assertion macros shared by the biquad filter RTL.
`ifndef BIQUAD_IIR_FIXED_POINT_TOP_MACROS_SVH
`define BIQUAD_IIR_FIXED_POINT_TOP_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define BQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("biquad: invariant violated");

// Check that a trigger in one cycle implies a condition in the next.
`define BQ_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("biquad: sequence violated");

`endif

@@ sv/biquad_pkg.sv @@
// Package with register map, reset values and shared types of the biquad filter.
`default_nettype none

package biquad_pkg;

    localparam int unsigned DataW = 16;
    localparam int unsigned AddrW = 5;
    localparam int unsigned BusW  = 32;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_B0    = 3'd0;
    localparam logic [2:0] REG_B1    = 3'd1;
    localparam logic [2:0] REG_B2    = 3'd2;
    localparam logic [2:0] REG_A1    = 3'd3;
    localparam logic [2:0] REG_A2    = 3'd4;
    localparam logic [2:0] REG_INIT1 = 3'd5;
    localparam logic [2:0] REG_INIT2 = 3'd6;

    // Reset values
    localparam logic signed [DataW-1:0] RST_B0    = 16'sh76B0;
    localparam logic signed [DataW-1:0] RST_B1    = 16'sh76B0;
    localparam logic signed [DataW-1:0] RST_B2    = 16'sh76B0;
    localparam logic signed [DataW-1:0] RST_A1    = 16'sd29863;
    localparam logic signed [DataW-1:0] RST_A2    = -16'sd27433;
    localparam logic signed [DataW-1:0] RST_INIT1 = 16'shC000;
    localparam logic signed [DataW-1:0] RST_INIT2 = 16'shC000;

    // Priming counter codes
    localparam logic [1:0] PRIME_NONE = 2'd0;
    localparam logic [1:0] PRIME_ONE  = 2'd1;
    localparam logic [1:0] PRIME_TWO  = 2'd2;

    // Rounding offsets for the five product terms
    localparam logic signed [32:0] RND_24 = 33'sd8388608;
    localparam logic signed [32:0] RND_23 = 33'sd4194304;
    localparam logic signed [32:0] RND_14 = 33'sd8192;
    localparam logic signed [32:0] RND_15 = 33'sd16384;

    // Filter coefficients and initial conditions
    typedef struct packed {
        logic signed [DataW-1:0] b0;
        logic signed [DataW-1:0] b1;
        logic signed [DataW-1:0] b2;
        logic signed [DataW-1:0] a1;
        logic signed [DataW-1:0] a2;
        logic signed [DataW-1:0] init1;
        logic signed [DataW-1:0] init2;
    } coef_t;

endpackage

`default_nettype wire

@@ sv/biquad_regs.sv @@
// Configuration register file of the biquad filter on an APB-style port.
`default_nettype none

module biquad_regs
    import biquad_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [BusW-1:0]  pwdata,
    output logic      [BusW-1:0]  prdata,
    output logic                  pready,
    output coef_t                 coef
);

    coef_t            coef_reg;
    coef_t            coef_next;
    logic [2:0]       reg_index;
    logic             wr_en;
    logic [DataW-1:0] wr_data;
    logic [DataW-1:0] rd_data;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign wr_data   = pwdata[DataW-1:0];
    assign coef      = coef_reg;

    // Decode the write request; ignore unknown indexes
    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_B0:    coef_next.b0    = wr_data;
                REG_B1:    coef_next.b1    = wr_data;
                REG_B2:    coef_next.b2    = wr_data;
                REG_A1:    coef_next.a1    = wr_data;
                REG_A2:    coef_next.a2    = wr_data;
                REG_INIT1: coef_next.init1 = wr_data;
                REG_INIT2: coef_next.init2 = wr_data;
                default:   coef_next       = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0    <= RST_B0;
            coef_reg.b1    <= RST_B1;
            coef_reg.b2    <= RST_B2;
            coef_reg.a1    <= RST_A1;
            coef_reg.a2    <= RST_A2;
            coef_reg.init1 <= RST_INIT1;
            coef_reg.init2 <= RST_INIT2;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    // Return the addressed register, sign-extended to the bus
    always_comb
    begin
        case (reg_index)
            REG_B0:    rd_data = coef_reg.b0;
            REG_B1:    rd_data = coef_reg.b1;
            REG_B2:    rd_data = coef_reg.b2;
            REG_A1:    rd_data = coef_reg.a1;
            REG_A2:    rd_data = coef_reg.a2;
            REG_INIT1: rd_data = coef_reg.init1;
            REG_INIT2: rd_data = coef_reg.init2;
            default:   rd_data = '0;
        endcase
    end

    assign prdata = {{(BusW-DataW){rd_data[DataW-1]}}, rd_data};

endmodule

`default_nettype wire

@@ sv/biquad_mac.sv @@
// Five-term multiply, round and sum of one biquad output sample.
`default_nettype none

module biquad_mac
    import biquad_pkg::*;
(
    input  wire coef_t                   coef,
    input  wire logic signed [DataW-1:0] x0,
    input  wire logic signed [DataW-1:0] x1,
    input  wire logic signed [DataW-1:0] x2,
    input  wire logic signed [DataW-1:0] y1,
    input  wire logic signed [DataW-1:0] y2,
    output logic signed [DataW-1:0] y0
);

    logic signed [31:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [32:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [32:0] s_b0, s_b1, s_b2, s_a1, s_a2;

    // Full 16x16 signed products
    assign p_b0 = coef.b0 * x0;
    assign p_b1 = coef.b1 * x1;
    assign p_b2 = coef.b2 * x2;
    assign p_a1 = coef.a1 * y1;
    assign p_a2 = coef.a2 * y2;

    // Add half an LSB of the target scale
    assign r_b0 = {p_b0[31], p_b0} + RND_24;
    assign r_b1 = {p_b1[31], p_b1} + RND_23;
    assign r_b2 = {p_b2[31], p_b2} + RND_24;
    assign r_a1 = {p_a1[31], p_a1} + RND_14;
    assign r_a2 = {p_a2[31], p_a2} + RND_15;

    // Floor-shift each term to Q2.14
    assign s_b0 = r_b0 >>> 24;
    assign s_b1 = r_b1 >>> 23;
    assign s_b2 = r_b2 >>> 24;
    assign s_a1 = r_a1 >>> 14;
    assign s_a2 = r_a2 >>> 15;

    // Sum modulo 2^16; only the low bits of each term matter
    assign y0 = s_b0[DataW-1:0] + s_b1[DataW-1:0] + s_b2[DataW-1:0]
              + s_a1[DataW-1:0] + s_a2[DataW-1:0];

endmodule

`default_nettype wire

@@ sv/biquad_iir_fixed_point_top.sv @@
// Top level of the direct-form-1 biquad filter: handshake, history and result stage.
//
// Usage:
//   Request channel: req_valid/req_stall carry sample and restart. A request is
//   taken at an edge where req_valid is high and req_stall is low.
//   Result channel: res_valid/res_stall carry filtered, taken the same way.
//   Coefficients and initial conditions sit on the APB-style port, registers
//   at byte addresses 0..24; pready is always high.
//   A request lands in an input register; the five 16x16 products, rounding
//   and 16-bit wrapping sum are combinational, and the result register is
//   loaded from them when a request that gives a result advances.
//   Throughput is one request per cycle while no held result stalls the input
//   register, bounded by the feedback of y[n-1] through the multiply-add path.
//   The first two requests after reset, and the two starting at a request
//   with restart set, only fill the input history and give no result; the
//   output history is loaded from the initial-condition registers then.
//   Reset clears both stages, zeroes the input history and arms priming.
//   While res_stall holds, the result waits; one more request may enter the
//   input register; if it gives a result, req_stall rises until the result is taken.
`default_nettype none
`include "biquad_iir_fixed_point_top_macros.svh"

module biquad_iir_fixed_point_top
    import biquad_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [AddrW-1:0]        paddr,
    input  wire logic [BusW-1:0]         pwdata,
    output logic      [BusW-1:0]         prdata,
    output logic                         pready,
    input  wire logic                    req_valid,
    output logic                         req_stall,
    input  wire logic signed [DataW-1:0] sample,
    input  wire logic                    restart,
    output logic                         res_valid,
    input  wire logic                    res_stall,
    output logic signed [DataW-1:0]      filtered
);

    coef_t coef;

    // Input stage
    logic                    in_valid_reg;
    logic signed [DataW-1:0] sample_reg;
    logic                    restart_reg;

    // Filter history
    logic signed [DataW-1:0] x1_reg, x1_next;
    logic signed [DataW-1:0] x2_reg, x2_next;
    logic signed [DataW-1:0] y1_reg, y1_next;
    logic signed [DataW-1:0] y2_reg, y2_next;
    logic [1:0]              prime_reg, prime_next;

    // Result stage
    logic                    out_valid_reg;
    logic signed [DataW-1:0] filtered_reg;

    logic                    req_take;
    logic                    advance;
    logic                    prime_start;
    logic [1:0]              prime_eff;
    logic                    produce;
    logic signed [DataW-1:0] y1_eff;
    logic signed [DataW-1:0] y2_eff;
    logic signed [DataW-1:0] y_new;

    biquad_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // Resolve priming for the request in the input stage
    assign prime_start = restart_reg || (prime_reg == PRIME_TWO);
    assign prime_eff   = prime_start ? PRIME_TWO : prime_reg;
    assign produce     = (prime_eff == PRIME_NONE);
    assign y1_eff      = prime_start ? coef.init1 : y1_reg;
    assign y2_eff      = prime_start ? coef.init2 : y2_reg;

    biquad_mac u_mac (
        .coef (coef),
        .x0   (sample_reg),
        .x1   (x1_reg),
        .x2   (x2_reg),
        .y1   (y1_eff),
        .y2   (y2_eff),
        .y0   (y_new)
    );

    // Advance when the request yields nothing or the result stage frees up
    assign advance   = in_valid_reg && (!produce || !out_valid_reg || !res_stall);
    assign req_stall = in_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    assign res_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    // Next history values
    always_comb
    begin
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        y1_next    = y1_reg;
        y2_next    = y2_reg;
        prime_next = prime_reg;
        if (advance)
        begin
            x2_next = x1_reg;
            x1_next = sample_reg;
            if (produce)
            begin
                y2_next    = y1_reg;
                y1_next    = y_new;
                prime_next = PRIME_NONE;
            end
            else
            begin
                y1_next    = y1_eff;
                y2_next    = y2_eff;
                prime_next = prime_eff - PRIME_ONE;
            end
        end
    end

    // Hold history and priming count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg    <= '0;
            x2_reg    <= '0;
            y1_reg    <= RST_INIT1;
            y2_reg    <= RST_INIT2;
            prime_reg <= PRIME_TWO;
        end
        else
        begin
            x1_reg    <= x1_next;
            x2_reg    <= x2_next;
            y1_reg    <= y1_next;
            y2_reg    <= y2_next;
            prime_reg <= prime_next;
        end
    end

    // Capture an incoming request; drop it once it has advanced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            sample_reg  <= sample;
            restart_reg <= restart;
        end
    end

    // Load a new result or retire the taken one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            filtered_reg <= y_new;
        end
    end

    // Checks on the stage control and priming
    `BQ_ASSERT_NEXT(a_result_loaded, clk, rst_n, advance && produce, out_valid_reg)
    `BQ_ASSERT_NEXT(a_result_kept, clk, rst_n, out_valid_reg && res_stall, out_valid_reg)
    `BQ_ASSERT_NEXT(a_restart_primes, clk, rst_n, advance && restart_reg, prime_reg == PRIME_ONE)
    `BQ_ASSERT_NEXT(a_prime_loads_init, clk, rst_n, advance && prime_start, y1_reg == $past(coef.init1))
    `BQ_ASSERT_ALWAYS(a_prime_range, clk, rst_n, prime_reg != 2'd3)

endmodule

`default_nettype wire

@@ tb/sv/tb_biquad_iir_fixed_point_top.sv @@
// Self-checking testbench for the biquad filter: directed and random sample streams.
`timescale 1ns / 100ps

module tb_biquad_iir_fixed_point_top;
    import biquad_pkg::*;

    localparam int unsigned NumRegs      = 7;
    localparam logic [2:0]  REG_UNMAPPED = 3'd7;
    localparam int unsigned DrainCycles  = 4;
    localparam int unsigned StuckLimit   = 2000;
    localparam int unsigned RandomPhases = 8;
    localparam int unsigned PhaseItems   = 200;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    psel      = 1'b0;
    logic                    penable   = 1'b0;
    logic                    pwrite    = 1'b0;
    logic [AddrW-1:0]        paddr     = '0;
    logic [BusW-1:0]         pwdata    = '0;
    logic [BusW-1:0]         prdata;
    logic                    pready;
    logic                    req_valid = 1'b0;
    logic                    req_stall;
    logic signed [DataW-1:0] sample    = '0;
    logic                    restart   = 1'b0;
    logic                    res_valid;
    logic                    res_stall = 1'b0;
    logic signed [DataW-1:0] filtered;

    // Shadow of the register file and the filter history
    logic signed [DataW-1:0] biquad_regs [NumRegs];
    logic signed [DataW-1:0] x_one_back;
    logic signed [DataW-1:0] x_two_back;
    logic signed [DataW-1:0] y_one_back;
    logic signed [DataW-1:0] y_two_back;
    logic [1:0]              priming_count;
    logic signed [DataW-1:0] pending_filtered [$];

    bit          quiet;
    int unsigned mismatch_count;
    int unsigned stuck_cycles;

    biquad_iir_fixed_point_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sample    (sample),
        .restart   (restart),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .filtered  (filtered)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Load reset values into the shadow state
    task automatic reset_biquad_state();
        biquad_regs[REG_B0]    = RST_B0;
        biquad_regs[REG_B1]    = RST_B1;
        biquad_regs[REG_B2]    = RST_B2;
        biquad_regs[REG_A1]    = RST_A1;
        biquad_regs[REG_A2]    = RST_A2;
        biquad_regs[REG_INIT1] = RST_INIT1;
        biquad_regs[REG_INIT2] = RST_INIT2;
        x_one_back    = '0;
        x_two_back    = '0;
        y_one_back    = RST_INIT1;
        y_two_back    = RST_INIT2;
        priming_count = PRIME_TWO;
    endtask

    // Round coef*value and shift right with floor semantics
    function automatic logic signed [63:0] rounded_term(input logic signed [DataW-1:0] coef,
                                                        input logic signed [DataW-1:0] value,
                                                        input int unsigned shift);
        logic signed [63:0] wide_coef;
        logic signed [63:0] wide_value;
        logic signed [63:0] product;
        wide_coef  = coef;
        wide_value = value;
        product    = wide_coef * wide_value + (64'sd1 <<< (shift - 1));
        return product >>> shift;
    endfunction

    // Advance the filter by one request and queue the output it produces
    task automatic compute_biquad_output(input logic signed [DataW-1:0] x, input logic rs);
        logic signed [63:0]      acc;
        logic signed [DataW-1:0] y;
        if (rs || priming_count == PRIME_TWO)
        begin
            y_one_back    = biquad_regs[REG_INIT1];
            y_two_back    = biquad_regs[REG_INIT2];
            priming_count = PRIME_TWO;
        end
        if (priming_count != PRIME_NONE)
        begin
            x_two_back    = x_one_back;
            x_one_back    = x;
            priming_count = priming_count - 2'd1;
        end
        else
        begin
            acc = rounded_term(biquad_regs[REG_B0], x, 24)
                + rounded_term(biquad_regs[REG_B1], x_one_back, 23)
                + rounded_term(biquad_regs[REG_B2], x_two_back, 24)
                + rounded_term(biquad_regs[REG_A1], y_one_back, 14)
                + rounded_term(biquad_regs[REG_A2], y_two_back, 15);
            y          = acc[DataW-1:0];
            x_two_back = x_one_back;
            x_one_back = x;
            y_two_back = y_one_back;
            y_one_back = y;
            pending_filtered.push_back(y);
        end
    endtask

    // Offer one request, hold it until taken, then predict its output
    task automatic send_sample(input logic signed [DataW-1:0] x, input logic rs);
        bit taken;
        if (!quiet && $urandom_range(99) < 4)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        req_valid <= 1'b1;
        sample    <= x;
        restart   <= rs;
        do
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        while (!taken);
        compute_biquad_output(x, rs);
    endtask

    // Drop valid and wait until every output is back and the pipe is empty
    task automatic wait_until_idle();
        req_valid <= 1'b0;
        while (pending_filtered.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, then the bus goes idle
    task automatic write_register(input logic [2:0] index, input logic signed [DataW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({index, 2'b00});
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        if (index < NumRegs)
            biquad_regs[index] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all_registers(input logic signed [DataW-1:0] b0,
                                       input logic signed [DataW-1:0] b1,
                                       input logic signed [DataW-1:0] b2,
                                       input logic signed [DataW-1:0] a1,
                                       input logic signed [DataW-1:0] a2,
                                       input logic signed [DataW-1:0] init1,
                                       input logic signed [DataW-1:0] init2);
        write_register(REG_B0, b0);
        write_register(REG_B1, b1);
        write_register(REG_B2, b2);
        write_register(REG_A1, a1);
        write_register(REG_A2, a2);
        write_register(REG_INIT1, init1);
        write_register(REG_INIT2, init2);
    endtask

    // Pick a 16-bit value, leaning toward the extremes now and then
    function automatic logic signed [DataW-1:0] random_word();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return DataW'($urandom);
        endcase
    endfunction

    // Reset values: priming, extreme samples, restart mid-stream and during priming
    task automatic test_reset_defaults();
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'sh4000, 1'b1);
        send_sample(16'shC000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sd100, 1'b1);
        send_sample(-16'sd100, 1'b1);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd6, 1'b0);
        wait_until_idle();
    endtask

    // Coefficients and initial conditions at their limits; sums wrap
    task automatic test_coefficient_extremes();
        write_all_registers(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                            16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        wait_until_idle();

        write_all_registers(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                            16'sh8000, 16'sh8000);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        wait_until_idle();

        // an unmapped address must leave the register file alone
        write_all_registers(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                            16'sh0000, 16'sh0000);
        write_register(REG_UNMAPPED, 16'sh5A5A);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        wait_until_idle();
    endtask

    // Long random streams under random settings; one phase runs without idling or backpressure
    task automatic test_random_stream();
        logic rs;
        for (int phase = 0; phase < RandomPhases; phase++)
        begin
            write_all_registers(random_word(), random_word(), random_word(), random_word(),
                                random_word(), random_word(), random_word());
            quiet = (phase == 3);
            for (int n = 0; n < PhaseItems; n++)
            begin
                rs = (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3);
                send_sample(random_word(), rs);
            end
            wait_until_idle();
            quiet = 1'b0;
        end
    endtask

    // Random backpressure on the output side
    always @(posedge clk)
    begin
        res_stall <= !quiet && ($urandom_range(99) < 10);
    end

    // Compare each output taken at the coming edge with the oldest prediction
    always @(negedge clk)
    begin : check_filtered
        logic signed [DataW-1:0] expected;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_filtered.size() == 0)
            begin
                $display("%0t: filtered expected none, actual %0d", $time, filtered);
                mismatch_count++;
            end
            else
            begin
                expected = pending_filtered.pop_front();
                if (filtered !== expected)
                begin
                    $display("%0t: filtered expected %0d, actual %0d",
                             $time, expected, filtered);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run if nothing moves for too long
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall) || (psel && penable))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= StuckLimit)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        quiet          = 1'b0;
        mismatch_count = 0;
        stuck_cycles   = 0;
        reset_biquad_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_coefficient_extremes();
        test_random_stream();

        wait_until_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
